>>> hdl/fss_pkg.sv
package fss_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SPS        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EVAL_START = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EVAL_END   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VAR_LIMIT  = 3'd4;

    localparam logic [6:0]  SPS_RESET        = 7'd10;
    localparam logic [5:0]  EVAL_START_RESET = 6'd3;
    localparam logic [6:0]  EVAL_END_RESET   = 7'd7;
    localparam logic        INVERT_RESET     = 1'b0;
    localparam logic [31:0] VAR_LIMIT_RESET  = 32'd5000000;

    localparam logic [1:0] NUDGE_NONE  = 2'd0;
    localparam logic [1:0] NUDGE_SKIP  = 2'd1;
    localparam logic [1:0] NUDGE_REUSE = 2'd2;

    typedef struct packed {
        logic [6:0]  samples_per_symbol;
        logic [5:0]  eval_start;
        logic [6:0]  eval_end;
        logic        invert_output;
        logic [31:0] variance_limit;
    } t_cfg;

    typedef enum logic [4:0] {
        OP_NOP    = 5'd0,
        OP_CLR    = 5'd1,
        OP_ACC    = 5'd2,
        OP_POS    = 5'd3,
        OP_VINIT  = 5'd4,
        OP_VPH    = 5'd5,
        OP_VSQ    = 5'd6,
        OP_VACC   = 5'd7,
        OP_VN1    = 5'd8,
        OP_VN2    = 5'd9,
        OP_VDEC   = 5'd10,
        OP_MODSUB = 5'd11,
        OP_DINIT  = 5'd12,
        OP_DSTEP  = 5'd13,
        OP_RWR    = 5'd14,
        OP_SCMP   = 5'd15,
        OP_PROD   = 5'd16,
        OP_EMIT   = 5'd17
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic sym_end;
        logic pos_ge;
        logic k_last;
        logic i_last;
        logic div_last;
        logic scan_last;
        logic out_busy;
    } t_stat;

endpackage

>>> hdl/fss_if.sv
interface fss_sample_if;
    logic                valid;
    logic                ready;
    logic signed [15:0]  sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface fss_result_if;
    logic        valid;
    logic        ready;
    logic        symbol_bit;
    logic [1:0]  timing_nudge;

    modport source (output valid, output symbol_bit, output timing_nudge, input ready);
    modport sink   (input valid, input symbol_bit, input timing_nudge, output ready);
endinterface

>>> hdl/fss_ctrl.sv
module fss_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  fss_pkg::t_stat  i_stat,
    output fss_pkg::t_cmd   o_cmd
);

    typedef enum logic [19:0] {
        ST_CLEAR = 20'h00001,
        ST_IDLE  = 20'h00002,
        ST_POS   = 20'h00004,
        ST_CHK   = 20'h00008,
        ST_VINIT = 20'h00010,
        ST_VPH   = 20'h00020,
        ST_VRD   = 20'h00040,
        ST_VSQ   = 20'h00080,
        ST_VACC  = 20'h00100,
        ST_VN1   = 20'h00200,
        ST_VN2   = 20'h00400,
        ST_VDEC  = 20'h00800,
        ST_MOD   = 20'h01000,
        ST_DINIT = 20'h02000,
        ST_DSTEP = 20'h04000,
        ST_RWR   = 20'h08000,
        ST_SRD   = 20'h10000,
        ST_SCMP  = 20'h20000,
        ST_PROD  = 20'h40000,
        ST_EMIT  = 20'h80000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = fss_pkg::OP_NOP;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.op = fss_pkg::OP_CLR;
                if (i_stat.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = fss_pkg::OP_ACC;
                    if (i_stat.sym_end) n_state = ST_POS;
                end
            end
            ST_POS: begin
                o_cmd.op = fss_pkg::OP_POS;
                n_state  = ST_CHK;
            end
            ST_CHK: begin
                n_state = i_stat.pos_ge ? ST_VINIT : ST_DINIT;
            end
            ST_VINIT: begin
                o_cmd.op = fss_pkg::OP_VINIT;
                n_state  = ST_VPH;
            end
            ST_VPH: begin
                o_cmd.op = fss_pkg::OP_VPH;
                n_state  = ST_VRD;
            end
            ST_VRD: begin
                n_state = ST_VSQ;
            end
            ST_VSQ: begin
                o_cmd.op = fss_pkg::OP_VSQ;
                n_state  = ST_VACC;
            end
            ST_VACC: begin
                o_cmd.op = fss_pkg::OP_VACC;
                n_state  = i_stat.k_last ? ST_VN1 : ST_VRD;
            end
            ST_VN1: begin
                o_cmd.op = fss_pkg::OP_VN1;
                n_state  = ST_VN2;
            end
            ST_VN2: begin
                o_cmd.op = fss_pkg::OP_VN2;
                n_state  = i_stat.i_last ? ST_VDEC : ST_VPH;
            end
            ST_VDEC: begin
                o_cmd.op = fss_pkg::OP_VDEC;
                n_state  = ST_MOD;
            end
            ST_MOD: begin
                if (i_stat.pos_ge) begin
                    o_cmd.op = fss_pkg::OP_MODSUB;
                end else begin
                    n_state = ST_DINIT;
                end
            end
            ST_DINIT: begin
                o_cmd.op = fss_pkg::OP_DINIT;
                n_state  = ST_DSTEP;
            end
            ST_DSTEP: begin
                o_cmd.op = fss_pkg::OP_DSTEP;
                if (i_stat.div_last) n_state = ST_RWR;
            end
            ST_RWR: begin
                o_cmd.op = fss_pkg::OP_RWR;
                n_state  = ST_SRD;
            end
            ST_SRD: begin
                n_state = ST_SCMP;
            end
            ST_SCMP: begin
                o_cmd.op = fss_pkg::OP_SCMP;
                n_state  = i_stat.scan_last ? ST_PROD : ST_SRD;
            end
            ST_PROD: begin
                o_cmd.op = fss_pkg::OP_PROD;
                n_state  = ST_EMIT;
            end
            ST_EMIT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.op = fss_pkg::OP_EMIT;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

>>> hdl/fss_dp.sv
module fss_dp #(
    parameter int VAR_SYMBOLS      = 16,
    parameter int LEVEL_RING_DEPTH = 16,
    parameter int MAX_SPS          = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fss_pkg::t_cfg       i_cfg,
    input  fss_pkg::t_cmd       i_cmd,
    output fss_pkg::t_stat      o_stat,
    input  logic signed [15:0]  i_sample,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic                o_symbol_bit,
    output logic [1:0]          o_timing_nudge
);

    localparam int STORE_DEPTH = VAR_SYMBOLS * MAX_SPS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int POS_W       = $clog2(2 * STORE_DEPTH);
    localparam int PS_W        = POS_W + 1;
    localparam int SPS_W       = $clog2(MAX_SPS + 1);
    localparam int SUM_W       = 17 + SPS_W;
    localparam int KW          = $clog2(VAR_SYMBOLS);
    localparam int S1_W        = 17 + KW;
    localparam int S2_W        = 32 + KW;
    localparam int NUM_W       = 2 * S1_W + 1;
    localparam int LIM_W       = 32 + $clog2(VAR_SYMBOLS * VAR_SYMBOLS + 1);
    localparam int BIG_W       = NUM_W + LIM_W;
    localparam int LR_AW       = $clog2(LEVEL_RING_DEPTH);
    localparam int DCNT_W      = $clog2(SUM_W);
    localparam int REM_W       = SPS_W + 1;

    // Phase store and level ring.
    logic signed [15:0] ps_mem [STORE_DEPTH];
    logic signed [15:0] lr_mem [LEVEL_RING_DEPTH];
    logic [LEVEL_RING_DEPTH-1:0] r_lr_valid;

    // Control state.
    logic [SPS_W-1:0]         r_idx;
    logic signed [SUM_W-1:0]  r_wsum;
    logic signed [SUM_W-1:0]  r_lsum;
    logic [POS_W-1:0]         r_pos;
    logic [1:0]               r_pending;
    logic [1:0]               r_act;
    logic signed [15:0]       r_held;
    logic                     r_skip;
    logic [LR_AW-1:0]         r_lr_pos;
    logic [ADDR_W-1:0]        r_clr;
    logic                     r_out_valid;
    logic                     r_out_bit;
    logic [1:0]               r_out_nudge;

    // Working registers.
    logic signed [15:0]       r_ps_rd;
    logic [ADDR_W-1:0]        r_vaddr;
    logic [SPS_W-1:0]         r_i;
    logic [KW-1:0]            r_k;
    logic signed [15:0]       r_x;
    logic [31:0]              r_sq;
    logic signed [S1_W-1:0]   r_s1;
    logic [S2_W-1:0]          r_s2;
    logic [NUM_W-2:0]         r_a;
    logic signed [2*S1_W-1:0] r_p;
    logic signed [NUM_W-1:0]  r_vmin;
    logic [SPS_W-1:0]         r_vpos;
    logic [LIM_W-1:0]         r_lim;
    logic                     r_neg;
    logic [SUM_W-1:0]         r_dq;
    logic [REM_W-1:0]         r_rem;
    logic [DCNT_W-1:0]        r_dcnt;
    logic signed [15:0]       r_lr_rd;
    logic                     r_lr_rdv;
    logic [LR_AW-1:0]         r_scan;
    logic signed [15:0]       r_mn;
    logic signed [15:0]       r_mx;
    logic signed [24:0]       r_prod;
    logic                     r_npos;
    logic                     r_cneg;

    logic [SPS_W-1:0]         sps;
    logic [POS_W-1:0]         period;
    logic signed [15:0]       acc_x;
    logic [SPS_W-1:0]         acc_idx;
    logic signed [SUM_W-1:0]  acc_w;
    logic signed [SUM_W-1:0]  acc_l;
    logic                     in_win;
    logic signed [SUM_W-1:0]  n_wsum;
    logic signed [SUM_W-1:0]  n_lsum;
    logic [SPS_W-1:0]         n_idx;
    logic [PS_W-1:0]          wa_sum;
    logic [ADDR_W-1:0]        wa;
    logic                     ps_we;
    logic [ADDR_W-1:0]        ps_waddr;
    logic signed [15:0]       ps_wdata;
    logic signed [NUM_W-1:0]  num;
    logic                     var_ok;
    logic [SPS_W-1:0]         half;
    logic [1:0]               vdec_code;
    logic [REM_W-1:0]         rem_sh;
    logic                     rem_ge;
    logic signed [15:0]       lvl;
    logic signed [15:0]       scan_val;
    logic signed [16:0]       center;
    logic signed [7:0]        ev_n;
    logic                     above;

    always_comb begin
        if (int'(i_cfg.samples_per_symbol) < 2) begin
            sps = SPS_W'(2);
        end else if (int'(i_cfg.samples_per_symbol) > MAX_SPS) begin
            sps = SPS_W'(MAX_SPS);
        end else begin
            sps = SPS_W'(i_cfg.samples_per_symbol);
        end
    end

    assign period = POS_W'(sps) * POS_W'(VAR_SYMBOLS);

    // A reused sample opens the next symbol from cleared sums.
    always_comb begin
        acc_x   = i_sample;
        acc_idx = r_idx;
        acc_w   = r_wsum;
        acc_l   = r_lsum;
        if (i_cmd.op == fss_pkg::OP_EMIT) begin
            acc_x   = r_held;
            acc_idx = '0;
            acc_w   = '0;
            acc_l   = '0;
        end
    end

    assign in_win = (10'(acc_idx) >= 10'(i_cfg.eval_start))
                 && (10'(acc_idx) < 10'(i_cfg.eval_end));
    assign n_wsum = in_win ? acc_w + SUM_W'(acc_x) : acc_w;
    assign n_lsum = acc_l + SUM_W'(acc_x);
    assign n_idx  = acc_idx + SPS_W'(1);
    assign wa_sum = PS_W'(r_pos) + PS_W'(acc_idx);
    assign wa     = (wa_sum >= PS_W'(STORE_DEPTH)) ? ADDR_W'(wa_sum - PS_W'(STORE_DEPTH))
                                                   : ADDR_W'(wa_sum);

    always_comb begin
        ps_we    = 1'b0;
        ps_waddr = wa;
        ps_wdata = acc_x;
        if (i_cmd.op == fss_pkg::OP_CLR) begin
            ps_we    = 1'b1;
            ps_waddr = r_clr;
            ps_wdata = '0;
        end else if (i_cmd.op == fss_pkg::OP_ACC) begin
            ps_we = !r_skip;
        end else if (i_cmd.op == fss_pkg::OP_EMIT) begin
            ps_we = (r_act == fss_pkg::NUDGE_REUSE);
        end
    end

    assign num    = $signed({1'b0, r_a}) - NUM_W'(r_p);
    assign var_ok = (r_vmin > 0)
                 && ({{LIM_W{1'b0}}, r_vmin} <= {{NUM_W{1'b0}}, r_lim});
    assign half   = sps >> 1;

    always_comb begin
        vdec_code = fss_pkg::NUDGE_NONE;
        if (var_ok) begin
            if (r_vpos != '0 && r_vpos < half) begin
                vdec_code = fss_pkg::NUDGE_SKIP;
            end else if (r_vpos >= half && r_vpos < sps - SPS_W'(1)) begin
                vdec_code = fss_pkg::NUDGE_REUSE;
            end
        end
    end

    assign rem_sh   = {r_rem[REM_W-2:0], r_dq[SUM_W-1]};
    assign rem_ge   = rem_sh >= REM_W'(sps);
    assign lvl      = 16'(r_neg ? (~r_dq + SUM_W'(1)) : r_dq);
    assign scan_val = r_lr_rdv ? r_lr_rd : 16'sd0;
    assign center   = 17'(r_mn) + 17'(r_mx);
    assign ev_n     = $signed({1'b0, i_cfg.eval_end}) - $signed({2'b0, i_cfg.eval_start});
    assign above    = r_npos ? ($signed({r_wsum, 1'b0}) > r_prod) : r_cneg;

    assign o_stat.clr_last  = (r_clr == ADDR_W'(STORE_DEPTH - 1));
    assign o_stat.sym_end   = !r_skip
                           && ((SPS_W + 1)'(r_idx) + (SPS_W + 1)'(1) >= (SPS_W + 1)'(sps));
    assign o_stat.pos_ge    = (r_pos >= period);
    assign o_stat.k_last    = (r_k == KW'(VAR_SYMBOLS - 1));
    assign o_stat.i_last    = (r_i == sps - SPS_W'(1));
    assign o_stat.div_last  = (r_dcnt == DCNT_W'(SUM_W - 1));
    assign o_stat.scan_last = (r_scan == LR_AW'(LEVEL_RING_DEPTH - 1));
    assign o_stat.out_busy  = r_out_valid && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_wsum      <= '0;
            r_lsum      <= '0;
            r_pos       <= '0;
            r_pending   <= fss_pkg::NUDGE_NONE;
            r_act       <= fss_pkg::NUDGE_NONE;
            r_held      <= '0;
            r_skip      <= 1'b0;
            r_lr_pos    <= '0;
            r_lr_valid  <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && i_cmd.op != fss_pkg::OP_EMIT) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_cmd.op)
                fss_pkg::OP_CLR: begin
                    r_clr <= r_clr + ADDR_W'(1);
                end
                fss_pkg::OP_ACC: begin
                    if (r_skip) begin
                        r_skip <= 1'b0;
                    end else begin
                        r_wsum <= n_wsum;
                        r_lsum <= n_lsum;
                        r_idx  <= n_idx;
                        r_held <= acc_x;
                        if (o_stat.sym_end) begin
                            r_act     <= r_pending;
                            r_pending <= fss_pkg::NUDGE_NONE;
                        end
                    end
                end
                fss_pkg::OP_POS: begin
                    r_pos <= r_pos + POS_W'(sps);
                end
                fss_pkg::OP_VDEC: begin
                    if (vdec_code != fss_pkg::NUDGE_NONE) r_pending <= vdec_code;
                end
                fss_pkg::OP_MODSUB: begin
                    r_pos <= r_pos - period;
                end
                fss_pkg::OP_RWR: begin
                    r_lr_valid[r_lr_pos] <= 1'b1;
                    if (r_lr_pos == LR_AW'(LEVEL_RING_DEPTH - 1)) begin
                        r_lr_pos <= '0;
                    end else begin
                        r_lr_pos <= r_lr_pos + LR_AW'(1);
                    end
                end
                fss_pkg::OP_EMIT: begin
                    r_out_valid <= 1'b1;
                    r_out_bit   <= above ^ i_cfg.invert_output;
                    r_out_nudge <= r_pending;
                    if (r_act == fss_pkg::NUDGE_REUSE) begin
                        r_wsum <= n_wsum;
                        r_lsum <= n_lsum;
                        r_idx  <= n_idx;
                    end else begin
                        r_wsum <= '0;
                        r_lsum <= '0;
                        r_idx  <= '0;
                    end
                    if (r_act == fss_pkg::NUDGE_SKIP) r_skip <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (ps_we) ps_mem[ps_waddr] <= ps_wdata;
        r_ps_rd <= ps_mem[r_vaddr];
        if (i_cmd.op == fss_pkg::OP_RWR) lr_mem[r_lr_pos] <= lvl;
        r_lr_rd  <= lr_mem[r_scan];
        r_lr_rdv <= r_lr_valid[r_scan];

        unique case (i_cmd.op)
            fss_pkg::OP_VINIT: begin
                r_lim <= LIM_W'(i_cfg.variance_limit) * LIM_W'(VAR_SYMBOLS * VAR_SYMBOLS);
                r_i   <= '0;
            end
            fss_pkg::OP_VPH: begin
                r_k     <= '0;
                r_vaddr <= ADDR_W'(r_i);
                r_s1    <= '0;
                r_s2    <= '0;
            end
            fss_pkg::OP_VSQ: begin
                r_x  <= r_ps_rd;
                r_sq <= 32'(r_ps_rd * r_ps_rd);
            end
            fss_pkg::OP_VACC: begin
                r_s1    <= r_s1 + S1_W'(r_x);
                r_s2    <= r_s2 + S2_W'(r_sq);
                r_k     <= r_k + KW'(1);
                r_vaddr <= r_vaddr + ADDR_W'(sps);
            end
            fss_pkg::OP_VN1: begin
                r_a <= (NUM_W - 1)'(r_s2) * (NUM_W - 1)'(VAR_SYMBOLS);
                r_p <= r_s1 * r_s1;
            end
            fss_pkg::OP_VN2: begin
                if (r_i == '0 || num < r_vmin) begin
                    r_vmin <= num;
                    r_vpos <= r_i;
                end
                r_i <= r_i + SPS_W'(1);
            end
            fss_pkg::OP_DINIT: begin
                r_neg  <= r_lsum[SUM_W-1];
                r_dq   <= r_lsum[SUM_W-1] ? SUM_W'(-r_lsum) : SUM_W'(r_lsum);
                r_rem  <= '0;
                r_dcnt <= '0;
            end
            fss_pkg::OP_DSTEP: begin
                r_rem  <= rem_ge ? rem_sh - REM_W'(sps) : rem_sh;
                r_dq   <= {r_dq[SUM_W-2:0], rem_ge};
                r_dcnt <= r_dcnt + DCNT_W'(1);
            end
            fss_pkg::OP_RWR: begin
                r_scan <= '0;
            end
            fss_pkg::OP_SCMP: begin
                if (r_scan == '0) begin
                    r_mn <= scan_val;
                    r_mx <= scan_val;
                end else begin
                    if (scan_val < r_mn) r_mn <= scan_val;
                    if (scan_val > r_mx) r_mx <= scan_val;
                end
                r_scan <= r_scan + LR_AW'(1);
            end
            fss_pkg::OP_PROD: begin
                r_prod <= center * ev_n;
                r_npos <= (ev_n > 0);
                r_cneg <= (center < 0);
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_symbol_bit   = r_out_bit;
    assign o_timing_nudge = r_out_nudge;

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == fss_pkg::OP_EMIT) |-> !(r_out_valid && !i_out_ready))
        else $error("Result produced while the output register was still occupied.");

    a_emit_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == fss_pkg::OP_EMIT) |=> r_out_valid)
        else $error("Produced result was not presented.");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == fss_pkg::OP_ACC) |-> ((SPS_W + 1)'(r_idx) < (SPS_W + 1)'(MAX_SPS)))
        else $error("Sample index ran past the longest symbol.");

    a_mod_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == fss_pkg::OP_MODSUB) |-> (r_pos >= period))
        else $error("Store position reduced below zero.");

endmodule

>>> hdl/fsk_symbol_slicer_timing.sv
// The last sample of a symbol starts a finishing sequence, during which no sample is accepted,
// whose length is set by the bit-serial level divider, of 24 steps at the default MAX_SPS,
// and by the scan of the level ring, which reads each entry and then compares it.
// Every VAR_SYMBOLS symbols the variance pass is added as well; each stored sample passes
// through the read, square and accumulate states at the single phase store read port.
// After reset the phase store is cleared entry by entry before any request is accepted.
module fsk_symbol_slicer_timing #(
    parameter int VAR_SYMBOLS      = 16,
    parameter int LEVEL_RING_DEPTH = 16,
    parameter int MAX_SPS          = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    fss_sample_if.sink                        i_sample_ch,
    fss_result_if.source                      o_result_ch,
    input  logic                              i_cfg_we,
    input  logic [fss_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [fss_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    fss_pkg::t_cfg  r_cfg;
    fss_pkg::t_cmd  cmd;
    fss_pkg::t_stat stat;
    logic           in_ready;
    logic           out_valid;
    logic           out_bit;
    logic [1:0]     out_nudge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.samples_per_symbol <= fss_pkg::SPS_RESET;
            r_cfg.eval_start         <= fss_pkg::EVAL_START_RESET;
            r_cfg.eval_end           <= fss_pkg::EVAL_END_RESET;
            r_cfg.invert_output      <= fss_pkg::INVERT_RESET;
            r_cfg.variance_limit     <= fss_pkg::VAR_LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fss_pkg::CFG_SPS:        r_cfg.samples_per_symbol <= i_cfg_data[6:0];
                fss_pkg::CFG_EVAL_START: r_cfg.eval_start         <= i_cfg_data[5:0];
                fss_pkg::CFG_EVAL_END:   r_cfg.eval_end           <= i_cfg_data[6:0];
                fss_pkg::CFG_INVERT:     r_cfg.invert_output      <= i_cfg_data[0];
                fss_pkg::CFG_VAR_LIMIT:  r_cfg.variance_limit     <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    fss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample_ch.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    fss_dp #(
        .VAR_SYMBOLS      (VAR_SYMBOLS),
        .LEVEL_RING_DEPTH (LEVEL_RING_DEPTH),
        .MAX_SPS          (MAX_SPS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_sample       (i_sample_ch.sample),
        .i_out_ready    (o_result_ch.ready),
        .o_out_valid    (out_valid),
        .o_symbol_bit   (out_bit),
        .o_timing_nudge (out_nudge)
    );

    assign i_sample_ch.ready        = in_ready;
    assign o_result_ch.valid        = out_valid;
    assign o_result_ch.symbol_bit   = out_bit;
    assign o_result_ch.timing_nudge = out_nudge;

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int VAR_SYM    = 16;
    localparam int RING_DEPTH = 16;
    localparam int LEN_MAX    = 64;
    localparam int STORE_SIZE = VAR_SYM * LEN_MAX;
    localparam int SETTLE     = 4000;
    localparam int CYCLE_CAP  = 3000000;
    localparam int ITEM_GOAL  = 1100;

    localparam logic [fss_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [fss_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [fss_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [fss_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    fss_sample_if smp_ch();
    fss_result_if res_ch();

    fsk_symbol_slicer_timing dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample_ch (smp_ch),
        .o_result_ch (res_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    typedef struct {
        logic       symbol_bit;
        logic [1:0] timing_nudge;
    } t_bit_rec;

    t_bit_rec bits_due[$];
    int mismatches = 0;
    int cycles = 0;
    int burst_left = 0;
    int items_sent = 0;

    // Slicer model state
    logic [6:0]  m_len_reg;
    logic [5:0]  m_start;
    logic [6:0]  m_end;
    logic        m_inv;
    logic [31:0] m_limit;
    logic signed [15:0] m_store [STORE_SIZE];
    logic signed [15:0] m_ring [RING_DEPTH];
    logic signed [15:0] m_held;
    int m_ring_pos, m_pos, m_idx, m_win, m_lvl;
    logic [1:0] m_pend;
    bit m_skip;

    task automatic slicer_init();
        m_len_reg = fss_pkg::SPS_RESET;
        m_start = fss_pkg::EVAL_START_RESET;
        m_end = fss_pkg::EVAL_END_RESET;
        m_inv = fss_pkg::INVERT_RESET;
        m_limit = fss_pkg::VAR_LIMIT_RESET;
        foreach (m_store[k]) m_store[k] = '0;
        foreach (m_ring[k]) m_ring[k] = '0;
        m_held = '0;
        m_ring_pos = 0;
        m_pos = 0;
        m_idx = 0;
        m_win = 0;
        m_lvl = 0;
        m_pend = fss_pkg::NUDGE_NONE;
        m_skip = 0;
    endtask

    function automatic int eff_len();
        int s;
        s = m_len_reg;
        if (s < 2) s = 2;
        if (s > LEN_MAX) s = LEN_MAX;
        return s;
    endfunction

    task automatic take_sample(input logic signed [15:0] x);
        if (m_idx >= m_start && m_idx < m_end) m_win += x;
        m_lvl += x;
        m_store[(m_pos + m_idx) % STORE_SIZE] = x;
        m_held = x;
        m_idx++;
    endtask

    function automatic void phase_variance(input int len);
        longint vmin, s1, s2, x, num, lim;
        int vpos;
        vmin = 0;
        vpos = 0;
        for (int i = 0; i < len; i++) begin
            s1 = 0;
            s2 = 0;
            for (int k = 0; k < VAR_SYM; k++) begin
                x = m_store[(k * len + i) % STORE_SIZE];
                s1 += x;
                s2 += x * x;
            end
            num = VAR_SYM * s2 - s1 * s1;
            if (i == 0 || num < vmin) begin
                vmin = num;
                vpos = i;
            end
        end
        lim = m_limit;
        lim = lim * VAR_SYM * VAR_SYM;
        if (vmin <= 0 || vmin > lim) begin
        end else if (vpos > 0 && vpos < len / 2) begin
            m_pend = fss_pkg::NUDGE_SKIP;
        end else if (vpos >= len / 2 && vpos < len - 1) begin
            m_pend = fss_pkg::NUDGE_REUSE;
        end
    endfunction

    function automatic logic close_symbol(input int len);
        int mn, mx, n;
        logic signed [15:0] lv;
        bit above;
        m_pos += len;
        if (m_pos >= VAR_SYM * len) begin
            phase_variance(len);
            m_pos = m_pos % (VAR_SYM * len);
        end
        lv = 16'(m_lvl / len);
        m_ring[m_ring_pos] = lv;
        m_ring_pos = (m_ring_pos + 1) % RING_DEPTH;
        mn = m_ring[0];
        mx = m_ring[0];
        for (int k = 1; k < RING_DEPTH; k++) begin
            if (m_ring[k] < mn) mn = m_ring[k];
            if (m_ring[k] > mx) mx = m_ring[k];
        end
        n = int'(m_end) - int'(m_start);
        if (n > 0) above = 2 * longint'(m_win) > longint'(mx + mn) * n;
        else above = 0 > (mx + mn);
        m_win = 0;
        m_lvl = 0;
        m_idx = 0;
        return above ^ m_inv;
    endfunction

    task automatic slice_sample(input logic signed [15:0] x);
        int len;
        logic [1:0] act;
        t_bit_rec r;
        len = eff_len();
        if (m_skip) begin
            m_skip = 0;
            return;
        end
        take_sample(x);
        if (m_idx < len) return;
        act = m_pend;
        m_pend = fss_pkg::NUDGE_NONE;
        r.symbol_bit = close_symbol(len);
        if (act == fss_pkg::NUDGE_REUSE) take_sample(m_held);
        else if (act == fss_pkg::NUDGE_SKIP) m_skip = 1;
        r.timing_nudge = m_pend;
        bits_due.push_back(r);
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: the stall behaviour is picked anew at random from four modes.
    int rcv_mode = 0;
    int rcv_left = 0;
    int stall_left = 0;
    initial res_ch.ready = 1'b0;
    always @(negedge i_clk) begin
        if (rcv_left == 0) begin
            rcv_mode = $urandom_range(0, 3);
            rcv_left = $urandom_range(50, 400);
        end
        rcv_left--;
        case (rcv_mode)
            0: res_ch.ready <= 1'b1;
            1: res_ch.ready <= $urandom_range(0, 1);
            2: res_ch.ready <= ($urandom_range(0, 3) == 0);
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    res_ch.ready <= 1'b0;
                end else begin
                    res_ch.ready <= 1'b1;
                    if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 40);
                end
            end
        endcase
    end

    always @(posedge i_clk) begin
        t_bit_rec want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (bits_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: bit %0b nudge %0d",
                             res_ch.symbol_bit, res_ch.timing_nudge);
            end else begin
                want = bits_due.pop_front();
                if (res_ch.symbol_bit !== want.symbol_bit ||
                    res_ch.timing_nudge !== want.timing_nudge) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected bit %0b nudge %0d, got bit %0b nudge %0d",
                                 want.symbol_bit, want.timing_nudge,
                                 res_ch.symbol_bit, res_ch.timing_nudge);
                end
            end
        end
    end

    task automatic send_sample(input logic signed [15:0] x);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 30);
            if (gap > 0) begin
                smp_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        smp_ch.valid <= 1'b1;
        smp_ch.sample <= x;
        do @(posedge i_clk); while (!smp_ch.ready);
        slice_sample(x);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic stop_sending();
        smp_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        while (bits_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [fss_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        case (idx)
            fss_pkg::CFG_SPS:        m_len_reg = data[6:0];
            fss_pkg::CFG_EVAL_START: m_start = data[5:0];
            fss_pkg::CFG_EVAL_END:   m_end = data[6:0];
            fss_pkg::CFG_INVERT:     m_inv = data[0];
            fss_pkg::CFG_VAR_LIMIT:  m_limit = data;
            default: ;
        endcase
    endtask

    task automatic set_all(input int len, input int es, input int ee, input bit inv,
                           input logic [31:0] lim);
        stop_sending();
        wait_idle();
        cfg_write(fss_pkg::CFG_SPS, len);
        cfg_write(fss_pkg::CFG_EVAL_START, es);
        cfg_write(fss_pkg::CFG_EVAL_END, ee);
        cfg_write(fss_pkg::CFG_INVERT, 32'(inv));
        cfg_write(fss_pkg::CFG_VAR_LIMIT, lim);
    endtask

    function automatic logic signed [15:0] clamp16(input int v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return 16'(v);
    endfunction

    // One symbol of a plateau waveform, optionally with a transition edge inside it.
    task automatic send_symbol(input int len, input int lvl, input int prev, input int edge_at,
                               input int noise);
        int v;
        for (int i = 0; i < len; i++) begin
            v = (i < edge_at) ? prev : lvl;
            v += $urandom_range(0, 2 * noise) - noise;
            send_sample(clamp16(v));
        end
    endtask

    task automatic test_directed();
        for (int i = 0; i < 10; i++) send_sample(16'sh7FFF);
        for (int i = 0; i < 10; i++) send_sample(-16'sh8000);
        send_sample(16'sd0);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        send_sample(16'sh5555);
    endtask

    task automatic test_config_extremes();
        set_all(0, 0, 1, 1'b1, 32'hFFFF_FFFF);
        for (int i = 0; i < 8; i++) send_sample(i[0] ? 16'sh7FFF : -16'sh8000);
        set_all(1, 5, 2, 1'b0, 32'd0);
        for (int i = 0; i < 8; i++) send_sample(16'($urandom));
        set_all(4, 2, 64, 1'b1, fss_pkg::VAR_LIMIT_RESET);
        for (int i = 0; i < 8; i++) send_sample(16'($urandom));
        set_all(127, 63, 64, 1'b0, 32'hAAAA_5555);
        for (int s = 0; s < 3; s++)
            send_symbol(64, s[0] ? 20000 : -20000, 0, $urandom_range(0, 63), 50);
        stop_sending();
        wait_idle();
        cfg_write(CFG_SPARE_HI, 32'hFFFF_FFFF);
        cfg_write(CFG_SPARE_LO, 32'h0);
        set_all(2, 0, 2, 1'b0, 32'h5555_AAAA);
        for (int i = 0; i < 8; i++) send_sample(16'($urandom));
    endtask

    task automatic test_random();
        int len, lvl, prev, edge_at, noise, count, amp;
        logic [31:0] lim;
        while (items_sent < ITEM_GOAL) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(2, 12);
            case ($urandom_range(0, 3))
                0: lim = 32'($urandom);
                1: lim = 32'hFFFF_FFFF;
                default: lim = fss_pkg::VAR_LIMIT_RESET * $urandom_range(1, 20);
            endcase
            if ($urandom_range(0, 3) == 0)
                set_all(len, $urandom_range(0, 63), $urandom_range(0, 127),
                        1'($urandom_range(0, 1)), lim);
            else
                set_all(len, (len + 1) / 3, (2 * len + 1) / 3, 1'($urandom_range(0, 1)), lim);
            count = (len > 12) ? 20 : $urandom_range(20, 40);
            amp = $urandom_range(1000, 32000);
            prev = 0;
            edge_at = $urandom_range(0, len - 1);
            for (int s = 0; s < count; s++) begin
                if (items_sent >= ITEM_GOAL) break;
                if ($urandom_range(0, 4) == 0) begin
                    for (int i = 0; i < len; i++) send_sample(16'($urandom));
                end else begin
                    lvl = $urandom_range(0, 1) ? amp : -amp;
                    noise = $urandom_range(0, 3) == 0 ? 2000 : $urandom_range(0, 100);
                    send_symbol(len, lvl, prev, edge_at, noise);
                    if ($urandom_range(0, 9) == 0) send_sample(clamp16(lvl));
                    prev = lvl;
                end
            end
        end
    endtask

    initial begin
        smp_ch.valid = 1'b0;
        smp_ch.sample = '0;
        slicer_init();
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_config_extremes();
        test_random();
        stop_sending();
        wait_idle();
        if (mismatches == 0 && bits_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
